### rtl/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Clocked, reset-gated property checks that report through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define LPD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("lpd assertion failed");

// When ante holds, cons must hold on the next clock edge.
`define LPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lpd assertion failed");

`endif

### rtl/lpd_pkg.sv
// Types, codes and id lookup tables for the link packet deframer.
// No dependencies; used by lpd_core, lpd_out_fifo and the top level.
package lpd_pkg;

    localparam logic [7:0] MARK_BYTE = 8'h98;
    localparam logic [7:0] FOLLOW_A  = 8'h15;
    localparam logic [7:0] FOLLOW_B  = 8'h56;

    // byte roles
    localparam logic [2:0] KIND_MID  = 3'd0;
    localparam logic [2:0] KIND_CMD  = 3'd1;
    localparam logic [2:0] KIND_LLO  = 3'd2;
    localparam logic [2:0] KIND_LHI  = 3'd3;
    localparam logic [2:0] KIND_DATA = 3'd4;
    localparam logic [2:0] KIND_CLO  = 3'd5;
    localparam logic [2:0] KIND_CHI  = 3'd6;
    localparam logic [2:0] KIND_ERR  = 3'd7;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_MACH = 2'd1;
    localparam logic [1:0] ERR_CMD  = 2'd2;

    typedef struct packed {
        logic [7:0] byte_value;
        logic [2:0] byte_kind;
        logic       direction;
        logic [4:0] command_index;
        logic       packet_end;
        logic       resynced;
        logic [1:0] error_code;
    } result_t;

    typedef struct packed {
        logic found;
        logic dir;
    } mach_hit_t;

    typedef struct packed {
        logic       found;
        logic [4:0] index;
        logic       has_data;
    } cmd_hit_t;

    // Machine ids; 0x00 and 0x08 resolve to host-to-calculator.
    function automatic mach_hit_t mach_lookup(input logic [7:0] b);
        mach_hit_t h;
        h = '0;
        case (b)
            8'h00, 8'h02, 8'h03, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h23: begin
                h.found = 1'b1;
                h.dir   = 1'b0;
            end
            8'h82, 8'h83, 8'h85, 8'h86, 8'h74, 8'h98, 8'h88, 8'h89, 8'h73: begin
                h.found = 1'b1;
                h.dir   = 1'b1;
            end
            default: h = '0;
        endcase
        return h;
    endfunction

    function automatic cmd_hit_t cmd_lookup(input logic [7:0] b);
        cmd_hit_t h;
        h = '0;
        case (b)
            8'h06: h = '{1'b1, 5'd0,  1'b1};
            8'h09: h = '{1'b1, 5'd1,  1'b0};
            8'h15: h = '{1'b1, 5'd2,  1'b1};
            8'h2D: h = '{1'b1, 5'd3,  1'b0};
            8'h36: h = '{1'b1, 5'd4,  1'b1};
            8'h47: h = '{1'b1, 5'd5,  1'b1};
            8'h56: h = '{1'b1, 5'd6,  1'b0};
            8'h5A: h = '{1'b1, 5'd7,  1'b1};
            8'h68: h = '{1'b1, 5'd8,  1'b0};
            8'h6D: h = '{1'b1, 5'd9,  1'b0};
            8'h74: h = '{1'b1, 5'd10, 1'b0};
            8'h78: h = '{1'b1, 5'd11, 1'b0};
            8'h87: h = '{1'b1, 5'd12, 1'b0};
            8'h88: h = '{1'b1, 5'd13, 1'b1};
            8'h92: h = '{1'b1, 5'd14, 1'b0};
            8'hA2: h = '{1'b1, 5'd15, 1'b1};
            8'hB7: h = '{1'b1, 5'd16, 1'b1};
            8'hC9: h = '{1'b1, 5'd17, 1'b1};
            default: h = '0;
        endcase
        return h;
    endfunction

    // data-carrying flag by table index
    function automatic logic cmd_has_data(input logic [4:0] idx);
        logic r;
        case (idx)
            5'd0, 5'd2, 5'd4, 5'd5, 5'd7, 5'd13, 5'd15, 5'd16, 5'd17: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

### rtl/lpd_core.sv
// Packet parser: phase state and per-word classification, up to two results a word.
// Depends on lpd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lpd_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        byte_in,
    input  logic              resync_en,
    output lpd_pkg::result_t  res0,
    output lpd_pkg::result_t  res1,
    output logic [1:0]        res_count
);

    localparam logic [2:0] PH_MID  = 3'd0;
    localparam logic [2:0] PH_CMD  = 3'd1;
    localparam logic [2:0] PH_LLO  = 3'd2;
    localparam logic [2:0] PH_LHI  = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_CLO  = 3'd5;
    localparam logic [2:0] PH_CHI  = 3'd6;

    logic [2:0]  phase_reg,   phase_next;
    logic [7:0]  len_lo_reg,  len_lo_next;
    logic [15:0] remain_reg,  remain_next;
    logic        dir_reg,     dir_next;
    logic [4:0]  cmd_reg,     cmd_next;
    logic        held_reg,    held_next;
    logic [1:0]  stopped_reg, stopped_next;

    always_comb begin
        lpd_pkg::result_t    hres;
        lpd_pkg::mach_hit_t  mh;
        lpd_pkg::cmd_hit_t   ch;
        logic                hvalid;
        logic                slot;
        logic [2:0]          hphase;
        logic                hdir;
        logic [15:0]         len;
        logic [15:0]         rem_dec;

        phase_next   = phase_reg;
        len_lo_next  = len_lo_reg;
        remain_next  = remain_reg;
        dir_next     = dir_reg;
        cmd_next     = cmd_reg;
        held_next    = held_reg;
        stopped_next = stopped_reg;
        res0         = '0;
        res1         = '0;
        res_count    = 2'd0;
        hres         = '0;
        hvalid       = 1'b0;
        slot         = 1'b0;
        hphase       = phase_reg;
        hdir         = dir_reg;
        mh           = lpd_pkg::mach_lookup(byte_in);
        ch           = lpd_pkg::cmd_lookup(byte_in);
        len          = {byte_in, len_lo_reg};
        rem_dec      = remain_reg - 16'd1;

        if (stopped_reg != lpd_pkg::ERR_NONE) begin
            res0.byte_value = byte_in;
            res0.byte_kind  = lpd_pkg::KIND_ERR;
            res0.error_code = stopped_reg;
            res_count       = 2'd1;
        end else begin
            if (held_reg) begin
                held_next       = 1'b0;
                slot            = 1'b1;
                res0.byte_value = lpd_pkg::MARK_BYTE;
                if (byte_in == lpd_pkg::FOLLOW_A || byte_in == lpd_pkg::FOLLOW_B) begin
                    // held marker opens a new packet
                    res0.byte_kind = lpd_pkg::KIND_MID;
                    res0.direction = 1'b1;
                    res0.resynced  = 1'b1;
                    dir_next       = 1'b1;
                    hdir           = 1'b1;
                    hphase         = PH_CMD;
                end else begin
                    res0.byte_kind     = lpd_pkg::KIND_DATA;
                    res0.direction     = dir_reg;
                    res0.command_index = cmd_reg;
                end
            end

            hres.byte_value    = byte_in;
            hres.direction     = hdir;
            hres.command_index = cmd_reg;
            hvalid             = 1'b1;
            case (hphase)
                PH_CMD: begin
                    if (!ch.found) begin
                        stopped_next = lpd_pkg::ERR_CMD;
                        hres         = '0;
                        hres.byte_value = byte_in;
                        hres.byte_kind  = lpd_pkg::KIND_ERR;
                        hres.error_code = lpd_pkg::ERR_CMD;
                    end else begin
                        cmd_next           = ch.index;
                        phase_next         = PH_LLO;
                        hres.byte_kind     = lpd_pkg::KIND_CMD;
                        hres.command_index = ch.index;
                    end
                end
                PH_LLO: begin
                    len_lo_next    = byte_in;
                    phase_next     = PH_LHI;
                    hres.byte_kind = lpd_pkg::KIND_LLO;
                end
                PH_LHI: begin
                    hres.byte_kind = lpd_pkg::KIND_LHI;
                    if (lpd_pkg::cmd_has_data(cmd_reg) && len != 16'd0) begin
                        remain_next = len;
                        phase_next  = PH_DATA;
                    end else begin
                        phase_next      = PH_MID;
                        hres.packet_end = 1'b1;
                    end
                end
                PH_DATA: begin
                    remain_next    = rem_dec;
                    hres.byte_kind = lpd_pkg::KIND_DATA;
                    if (rem_dec == 16'd0) begin
                        phase_next = PH_CLO;
                    end
                    // possible restart marker: hold it one word
                    if (resync_en && byte_in == lpd_pkg::MARK_BYTE) begin
                        held_next = 1'b1;
                        hvalid    = 1'b0;
                    end
                end
                PH_CLO: begin
                    phase_next     = PH_CHI;
                    hres.byte_kind = lpd_pkg::KIND_CLO;
                end
                PH_CHI: begin
                    phase_next      = PH_MID;
                    hres.byte_kind  = lpd_pkg::KIND_CHI;
                    hres.packet_end = 1'b1;
                end
                default: begin
                    hres.command_index = 5'd0;
                    if (!mh.found) begin
                        stopped_next = lpd_pkg::ERR_MACH;
                        hres         = '0;
                        hres.byte_value = byte_in;
                        hres.byte_kind  = lpd_pkg::KIND_ERR;
                        hres.error_code = lpd_pkg::ERR_MACH;
                    end else begin
                        dir_next       = mh.dir;
                        phase_next     = PH_CMD;
                        hres.byte_kind = lpd_pkg::KIND_MID;
                        hres.direction = mh.dir;
                    end
                end
            endcase

            if (slot) begin
                res1      = hres;
                res_count = hvalid ? 2'd2 : 2'd1;
            end else begin
                res0      = hres;
                res_count = hvalid ? 2'd1 : 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_MID;
            len_lo_reg  <= 8'd0;
            remain_reg  <= 16'd0;
            dir_reg     <= 1'b0;
            cmd_reg     <= 5'd0;
            held_reg    <= 1'b0;
            stopped_reg <= lpd_pkg::ERR_NONE;
        end else if (step) begin
            phase_reg   <= phase_next;
            len_lo_reg  <= len_lo_next;
            remain_reg  <= remain_next;
            dir_reg     <= dir_next;
            cmd_reg     <= cmd_next;
            held_reg    <= held_next;
            stopped_reg <= stopped_next;
        end
    end

    // error is sticky until reset
    `LPD_ASSERT_NEXT(a_stop_sticky, aclk, aresetn, stopped_reg != lpd_pkg::ERR_NONE,
                     stopped_reg == $past(stopped_reg))
    // a held marker only exists inside the data or checksum-low phase
    `LPD_ASSERT(a_held_phase, aclk, aresetn,
                !held_reg || phase_reg == PH_DATA || phase_reg == PH_CLO)
    // command index stays within the table
    `LPD_ASSERT(a_cmd_range, aclk, aresetn, cmd_reg <= 5'd17)

endmodule

### rtl/lpd_out_fifo.sv
// Result queue: takes up to two results a cycle, drains one a cycle on out_ready.
// Depends on lpd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lpd_out_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        push_n,
    input  lpd_pkg::result_t  push0,
    input  lpd_pkg::result_t  push1,
    output logic              room2,
    output logic              out_valid,
    input  logic              out_ready,
    output lpd_pkg::result_t  out_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    lpd_pkg::result_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             pop;
    logic [PTR_W-1:0] wr_ptr_p1;

    assign pop       = (count_reg != '0) && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign room2     = (count_reg <= CNT_W'(DEPTH - 2));
    assign wr_ptr_p1 = wr_ptr_reg + PTR_W'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push_n) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_n == 2'd2) begin
            mem[wr_ptr_p1] <= push1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `LPD_ASSERT(a_no_overflow, aclk, aresetn, count_reg <= CNT_W'(DEPTH))
    `LPD_ASSERT(a_push_room, aclk, aresetn, push_n == 2'd0 || room2)
    `LPD_ASSERT(a_push_code, aclk, aresetn, push_n != 2'd3)

endmodule

### rtl/link_packet_deframer_unit.sv
// Top level of the link packet deframer: input register, parser core, result queue.
// Depends on lpd_pkg, lpd_core and lpd_out_fifo.
//
//  port group   dir  tdata fields (lsb first)                         other
//  s_*          in   link_byte[7:0]                                     -
//  m_*          out  byte_value, direction, command_index, resynced,    tuser=byte_kind
//                    error_code (17 bits, padded to 24)                 tlast=packet_end
//  cfg_*        in   resync_enable                                      -
//
// One input word per cycle while the queue has room; a word's results reach m_* after
// acceptance through the input register and then the queue write.
// A word yields up to two results; the queue drains one per cycle while m_tready is high,
// so words that produce two results can back up s_tready once the queue fills.
// The core advances only when the queue has room for two results.
// aresetn is synchronous, active low; configuration is always ready.

module link_packet_deframer_unit #(
    parameter int FIFO_DEPTH = 4   // power of two, at least 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] link_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] byte_value, [8] direction, [13:9] command_index,
                                    // [14] resynced, [16:15] error_code, [23:17] zero
    output logic [2:0]  m_tuser,    // [2:0] byte_kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    logic             in_valid_reg;
    logic [7:0]       byte_reg;
    logic             resync_reg;
    logic             step;
    logic             room2;
    logic [1:0]       res_count;
    logic [1:0]       push_n;
    lpd_pkg::result_t res0;
    lpd_pkg::result_t res1;
    lpd_pkg::result_t out_word;

    assign cfg_ready = 1'b1;
    assign step      = in_valid_reg && room2;
    assign s_tready  = !in_valid_reg || step;
    assign push_n    = step ? res_count : 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            resync_reg   <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (cfg_valid && cfg_ready) begin
                resync_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

    lpd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .byte_in   (byte_reg),
        .resync_en (resync_reg),
        .res0      (res0),
        .res1      (res1),
        .res_count (res_count)
    );

    lpd_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_n    (push_n),
        .push0     (res0),
        .push1     (res1),
        .room2     (room2),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_word)
    );

    assign m_tdata = {7'd0, out_word.error_code, out_word.resynced, out_word.command_index,
                      out_word.direction, out_word.byte_value};
    assign m_tuser = out_word.byte_kind;
    assign m_tlast = out_word.packet_end;

endmodule
